// ===== rtl/lag_cross_correlation_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lag cross-correlation block
// Shared property forms, clocked and gated off by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef LAG_CROSS_CORRELATION_TOP_DEFINES_SVH
`define LAG_CROSS_CORRELATION_TOP_DEFINES_SVH

// same-cycle implication
`define LCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg
// Stream word layout, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int LAG_W    = 10;
    localparam int ANGLE_W  = 16;
    localparam int MEAN_W   = 32;

    // slave word: angle_x, angle_y, lag
    localparam int S_DATA_W    = 48;
    localparam int ANGLE_X_LSB = 0;
    localparam int ANGLE_Y_LSB = 16;
    localparam int LAG_LSB     = 32;

    // slave user: cmd, start_req
    localparam int S_USER_W       = 2;
    localparam int USER_CMD_BIT   = 0;
    localparam int USER_START_BIT = 1;

    // master word: lag_out, mean_product
    localparam int M_DATA_W    = 48;
    localparam int LAG_OUT_LSB = 0;
    localparam int MEAN_LSB    = 10;

    // master user: status, overflow
    localparam int M_USER_W        = 2;
    localparam int USER_STATUS_BIT = 0;
    localparam int USER_OVF_BIT    = 1;

    localparam logic CMD_PUSH     = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } lcc_state_t;

endpackage

// ===== rtl/lag_cross_correlation_top.sv =====
`timescale 1ns / 1ps
// Push: ready again the next cycle after it is accepted; no result.
// Query: result valid and ready again after one MAC pass over the pairs for the lag,
//   a drain of the read and product stages and one divide; a lag with no pairs
//   skips the pass and the divide. A stalled earlier result word holds the result.
// Ready only while idle; a waiting result does not block pushes.
// Reset clears count, overflow and control; sample stores keep old contents.
// ----------------------------------------------------------------------------
// lag_cross_correlation_top
// Unbiased lag cross-correlation over two stored angle series.
// ----------------------------------------------------------------------------
module lag_cross_correlation_top import lcc_pkg::*; #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // angle_x, angle_y, lag, zero pad
    input  logic [S_USER_W-1:0] s_tuser,   // cmd, start_req
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // lag_out, mean_product, zero pad
    output logic [M_USER_W-1:0] m_tuser    // status, overflow
);

    localparam int STORE_W = (SAMPLE_WIDTH < ANGLE_W) ? SAMPLE_WIDTH : ANGLE_W;
    localparam int AW      = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W   = (CNT_W > LAG_W) ? CNT_W : LAG_W;
    localparam int ACC_W   = 2 * STORE_W + CNT_W;

    lcc_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [LAG_W-1:0]       lag_reg, lag_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       pairs_reg, pairs_next;
    logic                   status_reg, status_next;
    logic [MEAN_W-1:0]      mean_reg, mean_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                   in_fire;
    logic                   cmd_in;
    logic                   start_in;
    logic [ANGLE_W-1:0]     ang_x;
    logic [ANGLE_W-1:0]     ang_y;
    logic [LAG_W-1:0]       lag_in;
    logic [CNT_W-1:0]       base_cnt;
    logic                   full;
    logic                   no_pairs;
    logic [CMP_W-1:0]       pairs_c;
    logic [CMP_W-1:0]       yaddr_c;
    logic                   out_load;

    logic                   wr_en;
    logic                   rd_en;
    logic                   rd_valid;
    logic [STORE_W-1:0]     rd_x;
    logic [STORE_W-1:0]     rd_y;
    logic                   mac_clr;
    logic                   mac_busy;
    logic signed [ACC_W-1:0] acc;
    logic                   div_start;
    logic                   div_done;
    logic signed [ACC_W-1:0] div_q;
    logic signed [ACC_W+MEAN_W-1:0] q_ext;

    assign cmd_in   = s_tuser[USER_CMD_BIT];
    assign start_in = s_tuser[USER_START_BIT];
    assign ang_x    = s_tdata[ANGLE_X_LSB +: ANGLE_W];
    assign ang_y    = s_tdata[ANGLE_Y_LSB +: ANGLE_W];
    assign lag_in   = s_tdata[LAG_LSB +: LAG_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;

    assign base_cnt = start_in ? '0 : count_reg;
    assign full     = (base_cnt == CNT_W'(MAX_SAMPLES));
    assign wr_en    = in_fire & (cmd_in == CMD_PUSH) & ~full;
    assign no_pairs = CMP_W'(lag_in) >= CMP_W'(count_reg);
    assign pairs_c  = CMP_W'(count_reg) - CMP_W'(lag_in);
    assign mac_clr  = in_fire & (cmd_in == CMD_QUERY);

    assign rd_en    = (state_reg == ST_MAC);
    assign yaddr_c  = CMP_W'(idx_reg) + CMP_W'(lag_reg);
    assign q_ext    = (ACC_W + MEAN_W)'(div_q);
    assign out_load = (state_reg == ST_OUT) & (~m_tvalid_reg | m_tready);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        lag_next    = lag_reg;
        idx_next    = idx_reg;
        pairs_next  = pairs_reg;
        status_next = status_reg;
        mean_next   = mean_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (cmd_in == CMD_PUSH) begin
                        if (start_in) begin
                            ovf_next = 1'b0;
                        end
                        if (full) begin
                            ovf_next   = 1'b1;
                            count_next = base_cnt;
                        end else begin
                            count_next = base_cnt + 1'b1;
                        end
                    end else begin
                        lag_next   = lag_in;
                        idx_next   = '0;
                        pairs_next = pairs_c[CNT_W-1:0];
                        if (no_pairs) begin
                            status_next = STATUS_EMPTY;
                            mean_next   = '0;
                            state_next  = ST_OUT;
                        end else begin
                            state_next  = ST_MAC;
                        end
                    end
                end
            end
            ST_MAC: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == pairs_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the read and product stages to empty into the sum
                if (!rd_valid && !mac_busy) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    status_next = STATUS_OK;
                    mean_next   = q_ext[MEAN_W-1:0];
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[LAG_OUT_LSB +: LAG_W] = lag_reg;
            m_tdata_next[MEAN_LSB +: MEAN_W]   = mean_reg;
            m_tuser_next[USER_STATUS_BIT]      = status_reg;
            m_tuser_next[USER_OVF_BIT]         = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lag_reg     <= lag_next;
        idx_reg     <= idx_next;
        pairs_reg   <= pairs_next;
        status_reg  <= status_next;
        mean_reg    <= mean_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    lcc_store #(
        .DEPTH  (MAX_SAMPLES),
        .DATA_W (STORE_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (base_cnt[AW-1:0]),
        .wr_x     (ang_x[STORE_W-1:0]),
        .wr_y     (ang_y[STORE_W-1:0]),
        .rd_en    (rd_en),
        .rd_xaddr (idx_reg[AW-1:0]),
        .rd_yaddr (yaddr_c[AW-1:0]),
        .rd_valid (rd_valid),
        .rd_x     (rd_x),
        .rd_y     (rd_y)
    );

    lcc_mac #(
        .DATA_W (STORE_W),
        .ACC_W  (ACC_W)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (mac_clr),
        .in_valid (rd_valid),
        .in_x     (rd_x),
        .in_y     (rd_y),
        .busy     (mac_busy),
        .acc      (acc)
    );

    lcc_div #(
        .NUM_W (ACC_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc),
        .divisor  (pairs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

// ===== rtl/lcc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_store
// Paired sample memories: one write port, one registered read per memory.
// ----------------------------------------------------------------------------
module lcc_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic [DATA_W-1:0]                 wr_x,
    input  logic [DATA_W-1:0]                 wr_y,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_xaddr,
    input  logic [$clog2(DEPTH)-1:0]          rd_yaddr,
    output logic                              rd_valid,
    output logic [DATA_W-1:0]                 rd_x,
    output logic [DATA_W-1:0]                 rd_y
);

    logic [DATA_W-1:0] x_mem [DEPTH];
    logic [DATA_W-1:0] y_mem [DEPTH];
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_x_reg;
    logic [DATA_W-1:0] rd_y_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_x_reg <= x_mem[rd_xaddr];
            rd_y_reg <= y_mem[rd_yaddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_x     = rd_x_reg;
    assign rd_y     = rd_y_reg;

endmodule

// ===== rtl/lcc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_mac
// Multiply-accumulate: registered product, then running sum.
// ----------------------------------------------------------------------------
module lcc_mac #(
    parameter int DATA_W = 16,
    parameter int ACC_W  = 43
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clr,
    input  logic                     in_valid,
    input  logic [DATA_W-1:0]        in_x,
    input  logic [DATA_W-1:0]        in_y,
    output logic                     busy,
    output logic signed [ACC_W-1:0]  acc
);

    logic                           prod_vld_reg;
    logic signed [2*DATA_W-1:0]     prod_reg;
    logic signed [2*DATA_W-1:0]     prod_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;

    assign prod_next = $signed(in_x) * $signed(in_y);

    // sum cannot leave ACC_W bits: |product| <= 2^(2*DATA_W-2), count < 2^CNT_W
    always_comb begin
        acc_next = acc_reg;
        if (clr) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign busy = in_valid | prod_vld_reg;
    assign acc  = acc_reg;

endmodule

// ===== rtl/lcc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_div
// Restoring divider, one quotient bit per cycle, signed dividend over a
// positive divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lcc_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 11
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  dividend,
    input  logic [DEN_W-1:0]         divisor,
    output logic                     done,
    output logic signed [NUM_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 neg_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;
    logic [DEN_W:0]       diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
            neg_reg <= dividend[NUM_W-1];
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== rtl/lcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks on the lag cross-correlation block, bound to the top.
// ----------------------------------------------------------------------------
`include "lag_cross_correlation_top_defines.svh"

module lcc_checker import lcc_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,   // angle_x, angle_y, lag, zero pad
    input logic [S_USER_W-1:0] s_tuser,   // cmd, start_req
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,   // lag_out, mean_product, zero pad
    input logic [M_USER_W-1:0] m_tuser    // status, overflow
);

    logic push_fire;
    logic query_fire;

    assign push_fire  = s_tvalid && s_tready && (s_tuser[USER_CMD_BIT] == CMD_PUSH);
    assign query_fire = s_tvalid && s_tready && (s_tuser[USER_CMD_BIT] == CMD_QUERY);

    // stalled result word holds
    `LCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // a lag without pairs reports a zero mean
    `LCC_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && (m_tuser[USER_STATUS_BIT] == STATUS_EMPTY), m_tdata[MEAN_LSB +: MEAN_W] == '0, "empty lag with nonzero mean")

    // a query keeps the input side closed on the next cycle
    `LCC_ASSERT_NEXT(a_query_busy, aclk, aresetn, query_fire, !s_tready, "ready right after a query")

    // the input side is ready again on the cycle after a push
    `LCC_ASSERT_NEXT(a_push_one, aclk, aresetn, push_fire, s_tready, "push held the input side")

endmodule

bind lag_cross_correlation_top lcc_checker u_lcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
